FILE: hdl/tpdrd_pkg.sv
// Shared types and constants of the two-plane delta run decoder.
package tpdrd_pkg;

    // Plane geometry.
    localparam int ROW_BYTES  = 2048;
    localparam int ROWS       = 512;
    localparam int ROW_SHIFT  = $clog2(ROW_BYTES);
    localparam int ADDR_W     = 20;
    localparam int PLANE_SIZE = ROW_BYTES * ROWS;
    localparam int CLR_W      = ADDR_W + 1;

    // Request kinds on the input stream.
    localparam logic [1:0] REQ_DELTA = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_BEGIN = 2'd3;

    // Parser phases.
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_FILL    = 3'd2;
    localparam logic [2:0] PH_LIT     = 3'd3;
    localparam logic [2:0] PH_REFUSED = 3'd4;

    // Run types.
    localparam logic [3:0] RUN_SKIP_B = 4'd1;
    localparam logic [3:0] RUN_SWAP_B = 4'd2;
    localparam logic [3:0] RUN_LIT_B  = 4'd3;
    localparam logic [3:0] RUN_FILL_B = 4'd4;
    localparam logic [3:0] RUN_FILL_W = 4'd7;
    localparam logic [3:0] RUN_SKIP_W = 4'd10;
    localparam logic [3:0] RUN_SWAP_W = 4'd12;
    localparam logic [3:0] RUN_LIT_W  = 4'd13;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_BADRUN  = 2'd2;
    localparam logic [1:0] ST_BADREG  = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_X   = 3'd0;
    localparam logic [2:0] REG_Y   = 3'd1;
    localparam logic [2:0] REG_W   = 3'd2;
    localparam logic [2:0] REG_H   = 3'd3;
    localparam logic [2:0] REG_BPP = 3'd4;

    // Work a request needs after its parse step.
    typedef enum logic [1:0] {
        WK_NONE,
        WK_LOOP,
        WK_SINGLE,
        WK_HREAD
    } t_work;

    typedef struct packed {
        logic [10:0] region_x;
        logic [8:0]  region_y;
        logic [11:0] region_w;
        logic [9:0]  region_h;
        logic [2:0]  bpp;
    } t_cfg;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr;
        logic latch;
        logic disp;
        logic wr;
        logic adv;
        logic single;
        logic hread;
        logic load_out;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic  clr_done;
        t_work work;
        logic  run_active;
        logic  skip_kind;
        logic  last_byte;
        logic  out_free;
    } t_sts;

endpackage

FILE: hdl/tpdrd_ctrl.sv
// Sequencing state machine of the two-plane delta run decoder.
module tpdrd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tpdrd_pkg::t_sts i_sts,
    output tpdrd_pkg::t_cmd o_cmd,
    output logic            o_in_ready
);
    import tpdrd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_CHK, S_RD, S_WR, S_ADV, S_HRD, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_single, n_single;

    // Next state and the mode of the current run.
    always_comb begin
        n_state  = r_state;
        n_single = r_single;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                unique case (i_sts.work)
                    WK_NONE:   n_state = S_DONE;
                    WK_HREAD:  n_state = S_HRD;
                    WK_LOOP: begin
                        n_state  = S_CHK;
                        n_single = 1'b0;
                    end
                    WK_SINGLE: begin
                        n_state  = S_RD;
                        n_single = 1'b1;
                    end
                    default:   n_state = S_DONE;
                endcase
            end
            S_CHK: begin
                priority if (!i_sts.run_active) n_state = S_DONE;
                else if (i_sts.skip_kind) n_state = S_ADV;
                else n_state = S_RD;
            end
            S_RD:    n_state = S_WR;
            S_WR:    n_state = i_sts.last_byte ? S_ADV : S_RD;
            S_ADV:   n_state = r_single ? S_DONE : S_CHK;
            S_HRD:   n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_single <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_single <= n_single;
        end
    end

    // Command decode.
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr      = (r_state == S_CLEAR);
        o_cmd.latch    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.disp     = (r_state == S_DISP);
        o_cmd.wr       = (r_state == S_WR);
        o_cmd.adv      = (r_state == S_ADV);
        o_cmd.single   = r_single;
        o_cmd.hread    = (r_state == S_HRD);
        o_cmd.load_out = (r_state == S_DONE) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: hdl/tpdrd_dpath.sv
// Datapath of the two-plane delta run decoder: planes, parser registers, result register.
module tpdrd_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tpdrd_pkg::t_cfg         i_cfg,
    input  tpdrd_pkg::t_cmd         i_cmd,
    output tpdrd_pkg::t_sts         o_sts,
    input  logic [1:0]              i_req_type,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_plane_sel,
    input  logic [19:0]             i_byte_addr,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [7:0]              o_read_data,
    output logic [1:0]              o_status
);
    import tpdrd_pkg::*;

    // Plane memories.
    logic [7:0] r_cur_mem  [PLANE_SIZE];
    logic [7:0] r_prev_mem [PLANE_SIZE];
    logic [7:0] r_cur_q, r_prev_q;

    // Latched request.
    logic [1:0]        r_req;
    logic [7:0]        r_data;
    logic              r_sel;
    logic [ADDR_W-1:0] r_addr;

    // Parser state.
    logic [15:0] r_col;
    logic [9:0]  r_rows;
    logic [2:0]  r_phase;
    logic [3:0]  r_kind;
    logic [7:0]  r_run;
    logic [31:0] r_fill;
    logic [1:0]  r_seen;
    logic        r_err;
    logic [1:0]  r_k;
    logic [7:0]  r_rd;
    logic [CLR_W-1:0] r_clr;
    logic        r_ovalid;
    logic [7:0]  r_orddata;
    logic [1:0]  r_ostatus;

    logic        wide_kind;
    logic [1:0]  last_k;
    logic [10:0] row;
    logic [13:0] x_bytes;
    logic [ADDR_W-1:0] elem_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0] fill_or;
    logic        valid_kind;
    logic        host_in_range;
    logic [7:0]  put_val;
    logic        is_swap;
    logic [12:0] pix_row;
    logic        region_ok;
    logic [14:0] lim;
    logic [15:0] col_step;
    logic [9:0]  rows_adv;
    logic [7:0]  run_adv;
    logic        blocked;
    t_work       work;

    logic              cur_we, prev_we;
    logic [ADDR_W-1:0] cur_wa, prev_wa;
    logic [7:0]        cur_wd, prev_wd;

    assign wide_kind = (r_kind == RUN_SKIP_W) || (r_kind == RUN_SWAP_W) ||
                       (r_kind == RUN_FILL_W) || (r_kind == RUN_LIT_W);
    assign last_k    = wide_kind ? 2'd3 : 2'd0;
    assign is_swap   = (r_kind == RUN_SWAP_B) || (r_kind == RUN_SWAP_W);
    assign blocked   = (r_phase == PH_REFUSED) || r_err;

    // Element address: bottom-up row, region origin, column offset and byte of the word.
    assign row       = 11'(i_cfg.region_y) + 11'(r_rows) - 11'd1;
    assign x_bytes   = 14'(i_cfg.region_x) * 14'(i_cfg.bpp);
    assign elem_addr = ADDR_W'({row[ADDR_W-ROW_SHIFT-1:0], {ROW_SHIFT{1'b0}}}
                       + 21'(x_bytes) + 21'(r_col) + 21'(r_k));
    assign rd_addr   = (r_req == REQ_READ) ? r_addr : elem_addr;
    assign host_in_range = (CLR_W'(r_addr) < CLR_W'(PLANE_SIZE));

    // Fill word with the current byte merged in.
    assign fill_or = r_fill | (32'(r_data) << {r_seen, 3'b000});

    assign valid_kind = (r_data == 8'(RUN_SKIP_B)) || (r_data == 8'(RUN_SWAP_B)) ||
                        (r_data == 8'(RUN_LIT_B))  || (r_data == 8'(RUN_FILL_B)) ||
                        (r_data == 8'(RUN_FILL_W)) || (r_data == 8'(RUN_SKIP_W)) ||
                        (r_data == 8'(RUN_SWAP_W)) || (r_data == 8'(RUN_LIT_W));

    // Region check at chunk begin; the pixel row length is a shift of the row bytes.
    always_comb begin
        pix_row   = 13'(ROW_BYTES);
        region_ok = 1'b1;
        unique case (i_cfg.bpp)
            3'd1:    pix_row = 13'(ROW_BYTES);
            3'd2:    pix_row = 13'(ROW_BYTES >> 1);
            3'd4:    pix_row = 13'(ROW_BYTES >> 2);
            default: region_ok = 1'b0;
        endcase
        if (13'(i_cfg.region_x) >= pix_row || 13'(i_cfg.region_y) >= 13'(ROWS))
            region_ok = 1'b0;
        if (13'(i_cfg.region_w) > pix_row || 13'(i_cfg.region_h) > 13'(ROWS))
            region_ok = 1'b0;
        if (13'(i_cfg.region_x) + 13'(i_cfg.region_w) > pix_row ||
            13'(i_cfg.region_y) + 13'(i_cfg.region_h) > 13'(ROWS))
            region_ok = 1'b0;
    end

    // What follows the parse step of the latched request.
    always_comb begin
        work = WK_NONE;
        unique case (r_req)
            REQ_READ:  work = WK_HREAD;
            REQ_DELTA: begin
                if (!blocked) begin
                    unique case (r_phase)
                        PH_LEN: begin
                            if (r_kind == RUN_SKIP_B || r_kind == RUN_SKIP_W ||
                                r_kind == RUN_SWAP_B || r_kind == RUN_SWAP_W)
                                work = WK_LOOP;
                        end
                        PH_FILL: begin
                            if (r_kind == RUN_FILL_B || r_seen == 2'd3)
                                work = WK_LOOP;
                        end
                        PH_LIT: begin
                            if (r_kind == RUN_LIT_B || r_seen == 2'd3)
                                work = WK_SINGLE;
                        end
                        default: work = WK_NONE;
                    endcase
                end
            end
            default:   work = WK_NONE;
        endcase
    end

    // Advance arithmetic.
    assign lim      = 15'(i_cfg.region_w) * 15'(i_cfg.bpp);
    assign col_step = r_col + (wide_kind ? 16'd4 : 16'd1);
    assign rows_adv = (col_step >= 16'(lim)) ? r_rows - 10'd1 : r_rows;
    assign run_adv  = r_run - 8'd1;

    // Byte stored by fill and literal runs.
    always_comb begin
        unique case (r_kind)
            RUN_LIT_B:  put_val = r_data;
            RUN_FILL_B: put_val = r_fill[7:0];
            default:    put_val = 8'(r_fill >> {r_k, 3'b000});
        endcase
    end

    // Plane write port selection.
    always_comb begin
        cur_we  = 1'b0;
        prev_we = 1'b0;
        cur_wa  = elem_addr;
        prev_wa = elem_addr;
        cur_wd  = is_swap ? r_prev_q : put_val;
        prev_wd = r_cur_q;
        priority if (i_cmd.clr) begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
            cur_wa  = r_clr[ADDR_W-1:0];
            prev_wa = r_clr[ADDR_W-1:0];
            cur_wd  = 8'd0;
            prev_wd = 8'd0;
        end else if (i_cmd.disp && r_req == REQ_WRITE) begin
            cur_we  = host_in_range && !r_sel;
            prev_we = host_in_range && r_sel;
            cur_wa  = r_addr;
            prev_wa = r_addr;
            cur_wd  = r_data;
            prev_wd = r_data;
        end else if (i_cmd.wr) begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
        end
    end

    // Plane memories with registered read.
    always_ff @(posedge i_clk) begin
        if (cur_we) r_cur_mem[cur_wa] <= cur_wd;
        r_cur_q <= r_cur_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) r_prev_mem[prev_wa] <= prev_wd;
        r_prev_q <= r_prev_mem[rd_addr];
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_data <= i_data_byte;
            r_sel  <= i_plane_sel;
            r_addr <= i_byte_addr;
        end
    end

    // Parser and run registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_rows  <= '0;
            r_phase <= PH_TYPE;
            r_kind  <= '0;
            r_run   <= '0;
            r_fill  <= '0;
            r_seen  <= '0;
            r_err   <= 1'b0;
            r_k     <= '0;
            r_rd    <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + CLR_W'(1);
            if (i_cmd.latch) r_rd <= '0;
            if (i_cmd.hread) r_rd <= host_in_range ? (r_sel ? r_prev_q : r_cur_q) : 8'd0;
            if (i_cmd.disp && r_req == REQ_BEGIN) begin
                r_err  <= 1'b0;
                r_col  <= '0;
                r_kind <= '0;
                r_run  <= '0;
                r_fill <= '0;
                r_seen <= '0;
                r_k    <= '0;
                if (region_ok) begin
                    r_phase <= PH_TYPE;
                    r_rows  <= i_cfg.region_h;
                end else begin
                    r_phase <= PH_REFUSED;
                    r_rows  <= '0;
                end
            end
            if (i_cmd.disp && r_req == REQ_DELTA && !blocked) begin
                r_k <= '0;
                unique case (r_phase)
                    PH_TYPE: begin
                        if (valid_kind) begin
                            r_kind  <= r_data[3:0];
                            r_phase <= PH_LEN;
                        end else begin
                            r_err <= 1'b1;
                        end
                    end
                    PH_LEN: begin
                        r_run   <= r_data;
                        r_phase <= PH_TYPE;
                        if (r_kind == RUN_FILL_B || r_kind == RUN_FILL_W) begin
                            r_fill  <= '0;
                            r_seen  <= '0;
                            r_phase <= PH_FILL;
                        end else if (r_kind == RUN_LIT_B || r_kind == RUN_LIT_W) begin
                            r_fill <= '0;
                            r_seen <= '0;
                            if (r_data != 8'd0 && r_rows != 10'd0) r_phase <= PH_LIT;
                        end
                    end
                    PH_FILL: begin
                        r_fill <= fill_or;
                        if (r_kind == RUN_FILL_B || r_seen == 2'd3) begin
                            r_seen  <= '0;
                            r_phase <= PH_TYPE;
                        end else begin
                            r_seen <= r_seen + 2'd1;
                        end
                    end
                    PH_LIT: begin
                        if (r_kind != RUN_LIT_B) begin
                            r_fill <= fill_or;
                            if (r_seen != 2'd3) r_seen <= r_seen + 2'd1;
                        end
                    end
                    default: r_phase <= r_phase;
                endcase
            end
            if (i_cmd.wr) r_k <= r_k + 2'd1;
            if (i_cmd.adv) begin
                r_k    <= '0;
                r_col  <= (col_step >= 16'(lim)) ? 16'd0 : col_step;
                r_rows <= rows_adv;
                r_run  <= run_adv;
                if (i_cmd.single) begin
                    if (r_kind == RUN_LIT_W) begin
                        r_fill <= '0;
                        r_seen <= '0;
                    end
                    if (run_adv == 8'd0 || rows_adv == 10'd0) r_phase <= PH_TYPE;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_orddata <= r_rd;
            priority if (r_phase == PH_REFUSED) r_ostatus <= ST_BADREG;
            else if (r_err) r_ostatus <= ST_BADRUN;
            else if (r_rows == 10'd0) r_ostatus <= ST_DONE;
            else r_ostatus <= ST_OK;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_read_data = r_orddata;
    assign o_status    = r_ostatus;

    // Status toward the controller.
    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = (r_clr[ADDR_W-1:0] == {ADDR_W{1'b1}});
        o_sts.work       = work;
        o_sts.run_active = (r_run != 8'd0) && (r_rows != 10'd0);
        o_sts.skip_kind  = (r_kind == RUN_SKIP_B) || (r_kind == RUN_SKIP_W);
        o_sts.last_byte  = (r_k == last_k);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

endmodule

FILE: hdl/two_plane_delta_run_decoder.sv
// Top level of the two-plane delta run decoder: stream ports, register file, controller, datapath.
// A write, a begin and a delta byte that starts no run go from acceptance through dispatch to the
// result register; a read adds a host read step. A looped run checks each element, then for byte
// and word updates reads and writes both planes per byte; a literal element reads and writes its
// bytes, then advances. Up to 255 elements a run. One request is in work at a time; the next is
// taken in the cycle after the result register is loaded, even while the result still waits.
// Reset (synchronous, active low) clears all control state, then a clearing pass zeroes both
// planes, one byte a cycle through 1048576 addresses, no request accepted; registers stay writable.
module two_plane_delta_run_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [7:0] data_byte, [27:8] byte_addr, [31:28] zero
    input  logic [2:0]  i_s_axis_tuser,   // [1:0] req_type, [2] plane_sel
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] read_data, [9:8] status, [15:10] zero
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import tpdrd_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       cfg_wr;

    // Register writes on the access cycle.
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{region_x: 11'd0, region_y: 9'd0, region_w: 12'd0, region_h: 10'd0,
                       bpp: 3'd1};
        end else if (cfg_wr) begin
            unique case (i_paddr[4:2])
                REG_X:   r_cfg.region_x <= i_pwdata[10:0];
                REG_Y:   r_cfg.region_y <= i_pwdata[8:0];
                REG_W:   r_cfg.region_w <= i_pwdata[11:0];
                REG_H:   r_cfg.region_h <= i_pwdata[9:0];
                REG_BPP: r_cfg.bpp      <= i_pwdata[2:0];
                default: r_cfg          <= r_cfg;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (i_paddr[4:2])
            REG_X:   o_prdata = 32'(r_cfg.region_x);
            REG_Y:   o_prdata = 32'(r_cfg.region_y);
            REG_W:   o_prdata = 32'(r_cfg.region_w);
            REG_H:   o_prdata = 32'(r_cfg.region_h);
            REG_BPP: o_prdata = 32'(r_cfg.bpp);
            default: o_prdata = 32'd0;
        endcase
    end

    tpdrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    tpdrd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_s_axis_tuser[1:0]),
        .i_data_byte (i_s_axis_tdata[7:0]),
        .i_plane_sel (i_s_axis_tuser[2]),
        .i_byte_addr (i_s_axis_tdata[27:8]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_read_data (read_data),
        .o_status    (status)
    );

    assign o_m_axis_tdata = {6'd0, status, read_data};

endmodule
